>>> hdl/jse_pkg.sv
// jse_pkg: beat types, command descriptor and character helpers for the
// json string escaper. No dependencies.
`timescale 1ns / 1ps

package jse_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] UNIT_REPL = 16'hFFFD;
    localparam logic [15:0] UNIT_HI   = 16'hD800;
    localparam logic [15:0] UNIT_LO   = 16'hDC00;
    localparam logic [20:0] PLANE1    = 21'h10000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       malformed;
    } t_out_beat;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_BYTE = 3'd1,
        K_ESC  = 3'd2,
        K_U16  = 3'd3,
        K_PAIR = 3'd4
    } t_kind;

    typedef struct packed {
        logic        bad_first;
        t_kind       kind;
        logic        mal;
        logic [7:0]  chr;
        logic [15:0] u0;
        logic [15:0] u1;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

    function automatic logic [7:0] u16_byte(input logic [15:0] unit, input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = CH_BSLASH;
            3'd1: c = CH_U;
            3'd2: c = hex_char(unit[15:12]);
            3'd3: c = hex_char(unit[11:8]);
            3'd4: c = hex_char(unit[7:4]);
            3'd5: c = hex_char(unit[3:0]);
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/jse_front.sv
// jse_front: accepts string beats, tracks the utf-8 sequence state and turns
// each character, start or end beat into one command. Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_accept,
    input  jse_pkg::t_in_beat i_in_beat,
    output logic            o_cmd_push,
    output jse_pkg::t_cmd   o_cmd
);
    import jse_pkg::*;

    logic        r_ascii_mode;
    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_left, n_left;

    logic [1:0]  op;
    logic [7:0]  b;
    logic        ok;
    logic        fresh;
    logic        emit;
    logic [20:0] acc_sh;
    logic [20:0] v;
    logic [7:0]  esc;
    t_cmd        cmd;

    assign op = i_in_beat.op;
    assign b  = i_in_beat.data_byte;
    assign acc_sh = {r_acc[14:0], b[5:0]};
    assign v = acc_sh - PLANE1;

    always_comb begin
        ok = (op == OP_DATA) && r_ascii_mode && (b[7:6] == 2'b10);
        if (r_left == 2'd3) begin
            if (r_acc == 21'd0 && b < 8'h90) ok = 1'b0;
            if (r_acc == 21'd4 && b > 8'h8F) ok = 1'b0;
        end
        if (r_left == 2'd2 && r_acc <= 21'hF) begin
            if (r_acc == 21'd0 && b < 8'hA0) ok = 1'b0;
            if (r_acc == 21'hD && b > 8'h9F) ok = 1'b0;
        end
    end

    always_comb begin
        case (b)
            8'h22:   esc = CH_QUOTE;
            8'h5C:   esc = CH_BSLASH;
            8'h08:   esc = 8'h62;
            8'h0C:   esc = 8'h66;
            8'h0A:   esc = 8'h6E;
            8'h0D:   esc = 8'h72;
            8'h09:   esc = 8'h74;
            default: esc = 8'h00;
        endcase
    end

    always_comb begin
        n_acc  = r_acc;
        n_left = r_left;
        emit   = 1'b0;
        fresh  = 1'b0;
        cmd    = '{bad_first: 1'b0, kind: K_NONE, mal: 1'b0, chr: 8'h00,
                   u0: 16'h0000, u1: 16'h0000};
        if (i_accept && op != OP_NONE) begin
            if (r_left != 2'd0) begin
                if (ok) begin
                    n_left = r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        n_acc = '0;
                        emit  = 1'b1;
                        if (acc_sh >= PLANE1) begin
                            cmd.kind = K_PAIR;
                            cmd.u0   = UNIT_HI + {6'd0, v[19:10]};
                            cmd.u1   = UNIT_LO + {6'd0, v[9:0]};
                        end else begin
                            cmd.kind = K_U16;
                            cmd.u0   = acc_sh[15:0];
                        end
                    end else begin
                        n_acc = acc_sh;
                    end
                end else begin
                    cmd.bad_first = 1'b1;
                    n_acc  = '0;
                    n_left = 2'd0;
                    fresh  = 1'b1;
                end
            end else begin
                fresh = 1'b1;
            end
            if (fresh) begin
                emit = 1'b1;
                if (op != OP_DATA) begin
                    cmd.kind = K_BYTE;
                    cmd.chr  = CH_QUOTE;
                end else if (esc != 8'h00) begin
                    cmd.kind = K_ESC;
                    cmd.chr  = esc;
                end else if (b < 8'h20) begin
                    cmd.kind = K_U16;
                    cmd.u0   = {8'h00, b};
                end else if (b >= 8'h80 && r_ascii_mode) begin
                    if (b inside {[8'hC2:8'hDF]}) begin
                        n_acc  = {16'd0, b[4:0]};
                        n_left = 2'd1;
                        emit   = cmd.bad_first;
                    end else if (b inside {[8'hE0:8'hEF]}) begin
                        n_acc  = {17'd0, b[3:0]};
                        n_left = 2'd2;
                        emit   = cmd.bad_first;
                    end else if (b inside {[8'hF0:8'hF4]}) begin
                        n_acc  = {18'd0, b[2:0]};
                        n_left = 2'd3;
                        emit   = cmd.bad_first;
                    end else begin
                        cmd.kind = K_U16;
                        cmd.u0   = UNIT_REPL;
                        cmd.mal  = 1'b1;
                    end
                end else begin
                    cmd.kind = K_BYTE;
                    cmd.chr  = b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_mode <= 1'b0;
            r_acc        <= '0;
            r_left       <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_ascii_mode <= i_cfg_wdata;
            end
            r_acc  <= n_acc;
            r_left <= n_left;
        end
    end

    assign o_cmd_push = emit;
    assign o_cmd      = cmd;

endmodule

>>> hdl/jse_cmd_fifo.sv
// jse_cmd_fifo: short command queue between front and back parts.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jse_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output jse_pkg::t_cmd o_rdata
);
    import jse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd];

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("command queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("command queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> r_count != CNT_FULL)
        else $error("command queue pushed while full");
`endif

endmodule

>>> hdl/jse_back.sv
// jse_back: expands queued commands into escaped output bytes, one beat a
// cycle through an output register while it is empty or popped. Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  jse_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               pop,
    output logic               empty,
    output jse_pkg::t_out_beat o_out_beat
);
    import jse_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_PRE   = 4'b0010,
        B_UNIT0 = 4'b0100,
        B_UNIT1 = 4'b1000
    } t_bstate;

    t_bstate   r_state, eff_state, next_seg;
    logic [2:0] r_pos, eff_pos;
    logic      r_out_valid;
    t_out_beat r_out;

    logic       advance;
    logic [7:0] byte_c;
    logic       mal_c;
    logic       seg_end;
    logic       done;

    assign advance = i_cmd_valid && (!r_out_valid || pop);

    always_comb begin
        if (r_state == B_IDLE) begin
            eff_state = i_cmd.bad_first ? B_PRE : B_UNIT0;
            eff_pos   = 3'd0;
        end else begin
            eff_state = r_state;
            eff_pos   = r_pos;
        end
    end

    always_comb begin
        byte_c   = 8'h00;
        mal_c    = 1'b0;
        seg_end  = 1'b0;
        done     = 1'b0;
        next_seg = B_UNIT0;
        case (eff_state)
            B_PRE: begin
                byte_c  = u16_byte(UNIT_REPL, eff_pos);
                mal_c   = 1'b1;
                seg_end = (eff_pos == 3'd5);
                done    = seg_end && (i_cmd.kind == K_NONE);
            end
            B_UNIT0: begin
                case (i_cmd.kind)
                    K_BYTE: begin
                        byte_c  = i_cmd.chr;
                        seg_end = 1'b1;
                        done    = 1'b1;
                    end
                    K_ESC: begin
                        byte_c  = (eff_pos == 3'd0) ? CH_BSLASH : i_cmd.chr;
                        seg_end = (eff_pos == 3'd1);
                        done    = seg_end;
                    end
                    K_U16: begin
                        byte_c  = u16_byte(i_cmd.u0, eff_pos);
                        mal_c   = i_cmd.mal;
                        seg_end = (eff_pos == 3'd5);
                        done    = seg_end;
                    end
                    K_PAIR: begin
                        byte_c   = u16_byte(i_cmd.u0, eff_pos);
                        seg_end  = (eff_pos == 3'd5);
                        next_seg = B_UNIT1;
                    end
                    default: begin
                        seg_end = 1'b1;
                        done    = 1'b1;
                    end
                endcase
            end
            B_UNIT1: begin
                byte_c  = u16_byte(i_cmd.u1, eff_pos);
                seg_end = (eff_pos == 3'd5);
                done    = seg_end;
            end
            default: begin
                seg_end = 1'b1;
                done    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            if (done) begin
                r_state <= B_IDLE;
                r_pos   <= 3'd0;
            end else if (seg_end) begin
                r_state <= next_seg;
                r_pos   <= 3'd0;
            end else begin
                r_state <= eff_state;
                r_pos   <= eff_pos + 3'd1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= '{out_byte: byte_c, last: done, malformed: mal_c};
        end
    end

    assign o_cmd_pop  = advance && done;
    assign empty      = !r_out_valid;
    assign o_out_beat = r_out;

`ifndef SYNTHESIS
    a_mid_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> i_cmd_valid)
        else $error("command left the queue before it was expanded");
    a_unit1_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_UNIT1) |-> (i_cmd.kind == K_PAIR))
        else $error("second unit reached for a non-pair command");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 3'd5)
        else $error("byte position out of range");
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_out_valid && r_out.last))
        else $error("command popped without its last beat");
`endif

endmodule

>>> hdl/json_string_escaper.sv
// json_string_escaper: top level, front classifier, command queue and back
// expander. Depends on jse_pkg, jse_front, jse_cmd_fifo, jse_back.
//
// channel | direction | handshake          | payload
// input   | in        | push / full        | i_in_beat   (op, data_byte)
// result  | out       | empty / pop        | o_out_beat  (out_byte, last, malformed)
// config  | in        | i_cfg_we           | i_cfg_wdata (ascii_mode)
//
// the back part emits one result beat a cycle while a command is queued and
// the output register is empty or popped; a beat escapes to 0 to 12 bytes,
// plain text at one beat a cycle; the front takes a beat every cycle until
// the CMD_DEPTH-entry queue fills; results pass the queue and output register
// reset is synchronous and clears utf-8 state, queue and output valid flag
`timescale 1ns / 1ps

module json_string_escaper #(
    parameter int CMD_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  jse_pkg::t_in_beat  i_in_beat,
    output logic               empty,
    input  logic               pop,
    output jse_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import jse_pkg::*;

    logic accept;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_valid;
    t_cmd cmd_w;
    t_cmd cmd_r;

    assign accept = push && !full;

    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in_beat   (i_in_beat),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_w)
    );

    jse_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_w),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_rdata (cmd_r)
    );

    jse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_r),
        .o_cmd_pop   (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .o_out_beat  (o_out_beat)
    );

endmodule
